// ===== rtl/heightmap_bilinear_sampler_defines.svh =====
// Assertion macros for the heightmap bilinear sampler
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define HBS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define HBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hbs_pkg.sv =====
// Constants and helper functions for the heightmap bilinear sampler
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int CELLS         = 64;
    localparam int FRACTION_BITS = 8;

    localparam int GRID_W   = 7;
    localparam int HEIGHT_W = 16;
    localparam int POS_W    = 24;
    localparam int INV_W    = 16;

    localparam logic [INV_W-1:0] INV_RESET = 16'd16384;

    localparam int IDX_W = $clog2(CELLS + 1);
    localparam int UW    = $clog2(CELLS);

    localparam int COORD_FRAC = POS_W - 16 + INV_W;
    localparam int PROD_W     = POS_W + 1 + INV_W + 1;
    localparam int C_W        = PROD_W + 1;
    localparam int HI_W       = C_W - 1 - COORD_FRAC;

    localparam logic signed [C_W-1:0] CELL_OFFSET = C_W'(CELLS) << (COORD_FRAC - 1);

    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BANK_SIDE  = CELLS / 2 + 1;
    localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
    localparam int BADDR_W    = $clog2(BANK_DEPTH);

    localparam int LERP_W = HEIGHT_W + 1 + FRACTION_BITS + 1;
    localparam logic signed [LERP_W-1:0] LERP_ROUND = LERP_W'(1) << (FRACTION_BITS - 1);

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // grid point (r, c) sits in bank {r[0], c[0]} at half-index (r/2, c/2)
    function automatic logic [BADDR_W-1:0] bank_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        return BADDR_W'(int'(r >> 1) * BANK_SIDE + int'(c >> 1));
    endfunction

    // a + floor((w*(b-a) + half) / 2^FRACTION_BITS)
    function automatic logic signed [HEIGHT_W-1:0] lerp(input logic signed [HEIGHT_W-1:0] a,
                                                        input logic signed [HEIGHT_W-1:0] b,
                                                        input logic [FRACTION_BITS-1:0] w);
        logic signed [HEIGHT_W:0]      diff;
        logic signed [FRACTION_BITS:0] ws;
        logic signed [LERP_W-1:0]      prod;
        logic signed [LERP_W-1:0]      step;
        diff = $signed({b[HEIGHT_W-1], b}) - $signed({a[HEIGHT_W-1], a});
        ws   = $signed({1'b0, w});
        prod = ws * diff + LERP_ROUND;
        step = prod >>> FRACTION_BITS;
        return a + step[HEIGHT_W-1:0];
    endfunction

endpackage

// ===== rtl/hbs_stream_if.sv =====
// Valid/ready stream interfaces for sampler items and results
`timescale 1ns / 1ps

interface hbs_in_if;
    import hbs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [GRID_W-1:0]          grid_row;
    logic [GRID_W-1:0]          grid_col;
    logic signed [HEIGHT_W-1:0] write_height;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;

    modport source (output valid, operation, grid_row, grid_col, write_height, pos_x, pos_y,
                    input ready);
    modport sink (input valid, operation, grid_row, grid_col, write_height, pos_x, pos_y,
                  output ready);
endinterface

interface hbs_out_if;
    import hbs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height;
    logic                       in_range;

    modport source (output valid, height, in_range, input ready);
    modport sink (input valid, height, in_range, output ready);
endinterface

// ===== rtl/hbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Top level of the heightmap bilinear sampler: coordinate pipeline, banked grid, interpolation
//
//  channel   dir  handshake     payload
//  item      in   valid/ready   operation, grid_row, grid_col, write_height, pos_x, pos_y
//  result    out  valid/ready   height, in_range (one per query, none per write)
//  cfg_wr    in   enable only   inverse_spacing
//
//  One item per cycle unless the output stalls. Query results leave from the output register.
//  Four parity banks (row and column parity) give all four corners in a single read;
//  writes and query reads share one access stage, so item order is kept at the memory.
//  Reset clears the stage valids and loads inverse_spacing with 16384; the grid is not cleared.
//  Stalls move back stage by stage; empty stages fill while the output waits.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_defines.svh"

module heightmap_bilinear_sampler (
    input  logic                      clk,
    input  logic                      rst_n,
    hbs_in_if.sink                    item,
    hbs_out_if.source                 result,
    input  logic                      cfg_wr_en,
    input  logic [hbs_pkg::INV_W-1:0] cfg_wr_data
);
    import hbs_pkg::*;

    logic [INV_W-1:0] inv_spacing_reg;

    // stage 1: accepted item
    logic                       s1_valid_reg;
    logic                       s1_query_reg;
    logic                       s1_wr_ok_reg;
    logic [IDX_W-1:0]           s1_row_reg;
    logic [IDX_W-1:0]           s1_col_reg;
    logic signed [HEIGHT_W-1:0] s1_wh_reg;
    logic signed [POS_W:0]      s1_px_reg;
    logic signed [POS_W:0]      s1_ny_reg;

    // stage 2: scaled coordinates
    logic                       s2_valid_reg;
    logic                       s2_query_reg;
    logic                       s2_wr_ok_reg;
    logic [IDX_W-1:0]           s2_row_reg;
    logic [IDX_W-1:0]           s2_col_reg;
    logic signed [HEIGHT_W-1:0] s2_wh_reg;
    logic signed [PROD_W-1:0]   s2_prod_x_reg;
    logic signed [PROD_W-1:0]   s2_prod_y_reg;

    // stage 3: cell and weights, memory access
    logic                       s3_valid_reg;
    logic                       s3_query_reg;
    logic                       s3_wr_ok_reg;
    logic [IDX_W-1:0]           s3_row_reg;
    logic [IDX_W-1:0]           s3_col_reg;
    logic signed [HEIGHT_W-1:0] s3_wh_reg;
    logic                       s3_in_range_reg;
    logic [UW-1:0]              s3_u_reg;
    logic [UW-1:0]              s3_v_reg;
    logic [FRACTION_BITS-1:0]   s3_wu_reg;
    logic [FRACTION_BITS-1:0]   s3_wv_reg;

    // stage 4: corner heights from the banks
    logic                       s4_valid_reg;
    logic                       s4_in_range_reg;
    logic                       s4_u0_reg;
    logic                       s4_v0_reg;
    logic [FRACTION_BITS-1:0]   s4_wu_reg;
    logic [FRACTION_BITS-1:0]   s4_wv_reg;

    // stage 5: interpolated along y
    logic                       s5_valid_reg;
    logic                       s5_in_range_reg;
    logic signed [HEIGHT_W-1:0] s5_a_reg;
    logic signed [HEIGHT_W-1:0] s5_b_reg;
    logic [FRACTION_BITS-1:0]   s5_wu_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [HEIGHT_W-1:0] out_height_reg;
    logic                       out_in_range_reg;

    logic ok_out, ok1, ok2, ok3, ok4, ok5;

    logic signed [INV_W:0]     inv_s;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [C_W-1:0]     coord_x;
    logic signed [C_W-1:0]     coord_y;
    logic                      in_x;
    logic                      in_y;

    logic [IDX_W-1:0]          u_ext;
    logic [IDX_W-1:0]          u_inc;
    logic [IDX_W-1:0]          v_ext;
    logic [IDX_W-1:0]          v_inc;
    logic                      wr_commit;
    logic [NUM_BANKS-1:0]      bank_we;
    logic [BADDR_W-1:0]        ram_waddr;
    logic [BADDR_W-1:0]        ram_raddr [NUM_BANKS];
    logic [HEIGHT_W-1:0]       ram_rdata [NUM_BANKS];
    logic                      ram_re;

    logic signed [HEIGHT_W-1:0] h00, h01, h10, h11;
    logic signed [HEIGHT_W-1:0] lerp_a, lerp_b, lerp_h;

    // stage enables
    assign ok_out = !out_valid_reg || result.ready;
    assign ok5    = !s5_valid_reg || ok_out;
    assign ok4    = !s4_valid_reg || ok5;
    assign ok3    = !s3_valid_reg || !s3_query_reg || ok4;
    assign ok2    = !s2_valid_reg || ok3;
    assign ok1    = !s1_valid_reg || ok2;

    assign item.ready = ok1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_spacing_reg <= INV_RESET;
        end
        else if (cfg_wr_en)
        begin
            inv_spacing_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ok1)
            begin
                s1_valid_reg <= item.valid;
            end
            if (ok2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ok3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ok4)
            begin
                s4_valid_reg <= s3_valid_reg && s3_query_reg;
            end
            if (ok5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (ok_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // stage 1 comb: scale by inverse spacing
    assign inv_s  = $signed({1'b0, inv_spacing_reg});
    assign prod_x = s1_px_reg * inv_s;
    assign prod_y = s1_ny_reg * inv_s;

    // stage 2 comb: offset by half the grid, bound check
    assign coord_x = s2_prod_x_reg + CELL_OFFSET;
    assign coord_y = s2_prod_y_reg + CELL_OFFSET;
    assign in_x    = !coord_x[C_W-1] && (coord_x[C_W-2:COORD_FRAC] < HI_W'(CELLS));
    assign in_y    = !coord_y[C_W-1] && (coord_y[C_W-2:COORD_FRAC] < HI_W'(CELLS));

    // stage 3 comb: bank addresses
    assign u_ext     = IDX_W'(s3_u_reg);
    assign u_inc     = u_ext + IDX_W'(1);
    assign v_ext     = IDX_W'(s3_v_reg);
    assign v_inc     = v_ext + IDX_W'(1);
    assign wr_commit = s3_valid_reg && !s3_query_reg && s3_wr_ok_reg;
    assign ram_waddr = bank_addr(s3_row_reg, s3_col_reg);
    assign ram_re    = ok4;

    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_we[b]   = wr_commit
                           && ({s3_row_reg[0], s3_col_reg[0]} == BANK_SEL_W'(b));
            ram_raddr[b] = bank_addr((s3_u_reg[0] == b[1]) ? u_ext : u_inc,
                                     (s3_v_reg[0] == b[0]) ? v_ext : v_inc);
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        hbs_ram #(
            .WIDTH(HEIGHT_W),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (bank_we[g]),
            .waddr(ram_waddr),
            .wdata(s3_wh_reg),
            .re   (ram_re),
            .raddr(ram_raddr[g]),
            .rdata(ram_rdata[g])
        );
    end

    // stage 4 comb: pick corners, interpolate along y
    assign h00    = $signed(ram_rdata[{s4_u0_reg, s4_v0_reg}]);
    assign h01    = $signed(ram_rdata[{s4_u0_reg, !s4_v0_reg}]);
    assign h10    = $signed(ram_rdata[{!s4_u0_reg, s4_v0_reg}]);
    assign h11    = $signed(ram_rdata[{!s4_u0_reg, !s4_v0_reg}]);
    assign lerp_a = lerp(h00, h01, s4_wv_reg);
    assign lerp_b = lerp(h10, h11, s4_wv_reg);

    // stage 5 comb: interpolate along x
    assign lerp_h = s5_in_range_reg ? lerp(s5_a_reg, s5_b_reg, s5_wu_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (ok1)
        begin
            s1_query_reg <= (item.operation == OP_QUERY);
            s1_wr_ok_reg <= (int'(item.grid_row) <= CELLS) && (int'(item.grid_col) <= CELLS);
            s1_row_reg   <= IDX_W'(item.grid_row);
            s1_col_reg   <= IDX_W'(item.grid_col);
            s1_wh_reg    <= item.write_height;
            s1_px_reg    <= $signed({item.pos_x[POS_W-1], item.pos_x});
            s1_ny_reg    <= -$signed({item.pos_y[POS_W-1], item.pos_y});
        end
        if (ok2)
        begin
            s2_query_reg  <= s1_query_reg;
            s2_wr_ok_reg  <= s1_wr_ok_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_wh_reg     <= s1_wh_reg;
            s2_prod_x_reg <= prod_x;
            s2_prod_y_reg <= prod_y;
        end
        if (ok3)
        begin
            s3_query_reg    <= s2_query_reg;
            s3_wr_ok_reg    <= s2_wr_ok_reg;
            s3_row_reg      <= s2_row_reg;
            s3_col_reg      <= s2_col_reg;
            s3_wh_reg       <= s2_wh_reg;
            s3_in_range_reg <= in_x && in_y;
            s3_u_reg        <= coord_x[COORD_FRAC +: UW];
            s3_v_reg        <= coord_y[COORD_FRAC +: UW];
            s3_wu_reg       <= coord_x[COORD_FRAC-1 -: FRACTION_BITS];
            s3_wv_reg       <= coord_y[COORD_FRAC-1 -: FRACTION_BITS];
        end
        if (ok4)
        begin
            s4_in_range_reg <= s3_in_range_reg;
            s4_u0_reg       <= s3_u_reg[0];
            s4_v0_reg       <= s3_v_reg[0];
            s4_wu_reg       <= s3_wu_reg;
            s4_wv_reg       <= s3_wv_reg;
        end
        if (ok5)
        begin
            s5_in_range_reg <= s4_in_range_reg;
            s5_a_reg        <= lerp_a;
            s5_b_reg        <= lerp_b;
            s5_wu_reg       <= s4_wu_reg;
        end
        if (ok_out)
        begin
            out_height_reg   <= lerp_h;
            out_in_range_reg <= s5_in_range_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.height   = out_height_reg;
    assign result.in_range = out_in_range_reg;

    `HBS_ASSERT_IMPLY(a_bank_we_onehot0, 1'b1, $onehot0(bank_we),
                      "more than one grid bank written in a cycle")
    `HBS_ASSERT_IMPLY(a_s4_hold_no_read, s4_valid_reg && !ok5, !ram_re,
                      "bank read while stage 4 holds its corners")
    `HBS_ASSERT_IMPLY(a_outside_zero, result.valid && !result.in_range, result.height == '0,
                      "outside query with nonzero height")
    `HBS_ASSERT_IMPLY(a_stall_root, !item.ready, out_valid_reg && !result.ready,
                      "input stalled without an output stall")
    `HBS_ASSERT_NEXT(a_write_no_result, ok4 && s3_valid_reg && !s3_query_reg, !s4_valid_reg,
                     "write transfer entered the result path")

endmodule

// ===== test/tb_heightmap_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// Testbench for heightmap_bilinear_sampler: grid loads, bilinear queries and spacing register
module tb_heightmap_bilinear_sampler;
    import hbs_pkg::*;

    localparam int     SIDE         = CELLS + 1;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     LIMIT_CYCLES = 400000;
    localparam int     WEIGHT_SHIFT = COORD_FRAC - FRACTION_BITS;
    localparam longint HALF_GRID    = longint'(CELLS) <<< (COORD_FRAC - 1);
    localparam longint POS_LIMIT    = (longint'(1) <<< (POS_W - 1)) - 1;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_range;
    } sample_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [INV_W-1:0] cfg_wr_data;

    hbs_in_if  item_bus ();
    hbs_out_if result_bus ();

    heightmap_bilinear_sampler uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic signed [HEIGHT_W-1:0] grid_model [SIDE*SIDE];
    bit                         grid_loaded [SIDE*SIDE];
    logic [INV_W-1:0]           spacing_model;
    sample_t                    pending_samples [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int mismatch_count  = 0;
    int samples_checked = 0;
    int inside_count    = 0;
    int query_count     = 0;
    int write_count     = 0;
    int cycle_count     = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // grid coordinate of one axis under the current spacing; 0 when the cell is off the grid
    function automatic bit map_axis(input longint p, output int cell_idx, output int weight);
        longint sp;
        longint c;
        longint cl;
        sp = longint'(spacing_model);
        c = p * sp + HALF_GRID;
        cell_idx = 0;
        weight = 0;
        if (c < 0)
            return 1'b0;
        cl = c >>> COORD_FRAC;
        if (cl >= CELLS)
            return 1'b0;
        cell_idx = int'(cl);
        weight = int'((c >>> WEIGHT_SHIFT) & ((longint'(1) <<< FRACTION_BITS) - 1));
        return 1'b1;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return a + ((w * (b - a) + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
    endfunction

    function automatic sample_t predict_sample(input logic signed [POS_W-1:0] px,
                                               input logic signed [POS_W-1:0] py);
        int      u;
        int      v;
        int      wu;
        int      wv;
        longint  a;
        longint  b;
        longint  h;
        sample_t s;
        s.height = '0;
        s.in_range = 1'b0;
        if (map_axis(longint'(px), u, wu) && map_axis(-longint'(py), v, wv))
        begin
            a = blend(grid_model[u*SIDE+v], grid_model[u*SIDE+v+1], wv);
            b = blend(grid_model[(u+1)*SIDE+v], grid_model[(u+1)*SIDE+v+1], wv);
            h = blend(a, b, wu);
            s.height = h[HEIGHT_W-1:0];
            s.in_range = 1'b1;
        end
        return s;
    endfunction

    // world position along one axis that lands near the given cell and weight
    function automatic longint axis_position(input int cell_idx, input int weight);
        longint sp;
        longint n;
        longint q;
        sp = longint'(spacing_model);
        if (sp == 0)
            return 0;
        n = (longint'(cell_idx) <<< COORD_FRAC) + (longint'(weight) <<< WEIGHT_SHIFT)
          + longint'($urandom_range((1 << WEIGHT_SHIFT) - 1)) - HALF_GRID;
        q = n / sp;
        if ((n % sp != 0) && (n < 0))
            q = q - 1;
        if (q > POS_LIMIT)
            q = POS_LIMIT;
        if (q < -POS_LIMIT)
            q = -POS_LIMIT;
        return q;
    endfunction

    task automatic send_item(input op_t                        op,
                             input logic [GRID_W-1:0]          row,
                             input logic [GRID_W-1:0]          col,
                             input logic signed [HEIGHT_W-1:0] h,
                             input logic signed [POS_W-1:0]    px,
                             input logic signed [POS_W-1:0]    py);
        int idx;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.operation    <= op;
        item_bus.grid_row     <= row;
        item_bus.grid_col     <= col;
        item_bus.write_height <= h;
        item_bus.pos_x        <= px;
        item_bus.pos_y        <= py;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (op == OP_WRITE)
        begin
            write_count++;
            if (row <= CELLS && col <= CELLS)
            begin
                idx = row * SIDE + col;
                grid_model[idx] = h;
                grid_loaded[idx] = 1'b1;
            end
        end
        else
        begin
            query_count++;
            pending_samples.push_back(predict_sample(px, py));
        end
    endtask

    // load any corner of the query's cell that has not been written yet
    task automatic load_corners(input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py);
        int u;
        int v;
        int wu;
        int wv;
        if (map_axis(longint'(px), u, wu) && map_axis(-longint'(py), v, wv))
        begin
            for (int dr = 0; dr < 2; dr++)
                for (int dc = 0; dc < 2; dc++)
                    if (!grid_loaded[(u+dr)*SIDE+v+dc])
                        send_item(OP_WRITE, GRID_W'(u + dr), GRID_W'(v + dc),
                                  HEIGHT_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    task automatic send_query(input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] py);
        load_corners(px, py);
        send_item(OP_QUERY, GRID_W'($urandom), GRID_W'($urandom), HEIGHT_W'($urandom), px, py);
    endtask

    task automatic query_near(input int u, input int wu, input int v, input int wv);
        longint px;
        longint py;
        px = axis_position(u, wu);
        py = -axis_position(v, wv);
        send_query(POS_W'(px), POS_W'(py));
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_spacing(input logic [INV_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        spacing_model = value;
    endtask

    task automatic test_grid_writes();
        send_item(OP_WRITE, 7'd0, 7'd0, -16'sd32768, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd0, 7'd1, 16'sd32767, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd1, 7'd0, 16'sd0, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd1, 7'd1, -16'sd1, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd64, 7'd64, 16'sh1234, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd63, 7'd64, -16'sd32768, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd64, 7'd63, 16'sd32767, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd63, 7'd63, 16'sd5, 24'sd0, 24'sd0);
        // rows or columns past the grid edge must leave it untouched
        send_item(OP_WRITE, 7'd65, 7'd0, 16'sd777, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd0, 7'd127, 16'sd777, 24'sd0, 24'sd0);
        send_item(OP_WRITE, 7'd127, 7'd127, 16'sd777, 24'sd0, 24'sd0);
    endtask

    task automatic test_reset_spacing();
        send_query(-24'sd32768, 24'sd32768);
        send_query(24'sd32767, -24'sd32767);
        send_query(24'sd32768, 24'sd0);
        send_query(-24'sd32769, 24'sd0);
        send_query(24'sd0, 24'sd0);
        send_query(24'sh7FFFFF, 24'sh800000);
    endtask

    task automatic test_spacing_extremes();
        set_spacing(16'd0);
        send_query(POS_W'($urandom), POS_W'($urandom));
        set_spacing(16'd1);
        send_query(24'sh7FFFFF, 24'sh800000);
        set_spacing(16'hFFFF);
        query_near(0, 0, 0, 0);
        query_near(CELLS - 1, 255, CELLS - 1, 255);
        query_near(31, 128, 17, 3);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [INV_W-1:0] spacing, input int count);
        int pick;
        set_spacing(spacing);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                query_near($urandom_range(CELLS - 1), $urandom_range(255),
                           $urandom_range(CELLS - 1), $urandom_range(255));
            else if (pick < 63)
                send_query(POS_W'($urandom), POS_W'($urandom));
            else if (pick < 95)
                send_item(OP_WRITE, GRID_W'($urandom_range(CELLS)), GRID_W'($urandom_range(CELLS)),
                          HEIGHT_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            else
                send_item(OP_WRITE, GRID_W'($urandom), GRID_W'($urandom),
                          HEIGHT_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    always @(posedge clk)
        result_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_result
        sample_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected result transfer: height %0d in_range %0b",
                       result_bus.height, result_bus.in_range);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (want.in_range)
                    inside_count++;
                if (result_bus.height !== want.height)
                begin
                    $error("height: expected %0d, actual %0d", want.height, result_bus.height);
                    mismatch_count++;
                end
                if (result_bus.in_range !== want.in_range)
                begin
                    $error("in_range: expected %0b, actual %0b", want.in_range,
                           result_bus.in_range);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
                     pending_samples.size());
            $display("** heightmap_bilinear_sampler: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        item_bus.valid        = 1'b0;
        item_bus.operation    = OP_WRITE;
        item_bus.grid_row     = '0;
        item_bus.grid_col     = '0;
        item_bus.write_height = '0;
        item_bus.pos_x        = '0;
        item_bus.pos_y        = '0;
        result_bus.ready      = 1'b0;
        spacing_model         = INV_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_grid_writes();
        test_reset_spacing();
        test_spacing_extremes();
        test_random_traffic(28, 83, INV_W'($urandom_range(1024, 65535)), 100);
        test_random_traffic(83, 28, 16'hFFFF, 100);
        test_random_traffic(0, 0, INV_W'($urandom_range(1, 65535)), 100);
        wait_idle();

        $display("%0d queries and %0d grid writes sent; %0d samples checked, %0d inside the grid",
                 query_count, write_count, samples_checked, inside_count);
        $display("spacing at reset value, 0, 1, full scale and random; three idle mixes");
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("** heightmap_bilinear_sampler: PASSED **");
        else
            $display("** heightmap_bilinear_sampler: FAILED **");
        $finish;
    end

endmodule
